FILE: hdl/calendar_time_step_adjuster_core_assert.svh
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_TIME_STEP_ADJUSTER_CORE_ASSERT_SVH
`define CALENDAR_TIME_STEP_ADJUSTER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CTSA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define CTSA_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: hdl/ctsa_pkg.sv
// Package for the calendar clock: command codes, field limits and calendar functions.
`default_nettype none

package ctsa_pkg;

    typedef enum logic [3:0] {
        CMD_SEC_UP    = 4'd0,
        CMD_SEC_DOWN  = 4'd1,
        CMD_MIN_UP    = 4'd2,
        CMD_MIN_DOWN  = 4'd3,
        CMD_HOUR_UP   = 4'd4,
        CMD_HOUR_DOWN = 4'd5,
        CMD_DAY_UP    = 4'd6,
        CMD_DAY_DOWN  = 4'd7,
        CMD_CLAMP_DAY = 4'd8,
        CMD_LOAD      = 4'd9,
        CMD_READ      = 4'd10
    } ctsa_cmd_t;

    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] DAY_MAX    = 5'd31;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [5:0] SECOND_MAX = 6'd59;

    localparam logic [6:0] RST_YEAR    = 7'd26;
    localparam logic [3:0] RST_MONTH   = 4'd7;
    localparam logic [4:0] RST_DAY     = 5'd26;
    localparam logic [4:0] RST_HOUR    = 5'd20;
    localparam logic [5:0] RST_MINUTE  = 6'd37;
    localparam logic [5:0] RST_SECOND  = 6'd55;
    localparam logic [2:0] RST_WEEKDAY = 3'd7;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Days in a month; every year divisible by four is leap, year 0 included.
    function automatic logic [4:0] month_len(input logic [6:0] year, input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(3 * (m + 1) / 5), with January and February counted as months 13 and 14.
    function automatic logic [3:0] month_term(input logic [3:0] month);
        logic [3:0] t;
        case (month)
            4'd1:    t = 4'd8;
            4'd2:    t = 4'd9;
            4'd3:    t = 4'd2;
            4'd4:    t = 4'd3;
            4'd5:    t = 4'd3;
            4'd6:    t = 4'd4;
            4'd7:    t = 4'd4;
            4'd8:    t = 4'd5;
            4'd9:    t = 4'd6;
            4'd10:   t = 4'd6;
            4'd11:   t = 4'd7;
            4'd12:   t = 4'd7;
            default: t = 4'd0;
        endcase
        return t;
    endfunction

    // Weekday 1..7 (Monday..Sunday) of 2000 + year. Over 1999..2099 the century
    // terms are constant, so the full-year sum reduces to 2480 + j + j/4 with
    // j = year + 4 (year + 3 for January and February); 2480 is 2 modulo 7.
    function automatic logic [2:0] weekday_of(input logic [6:0] year, input logic [3:0] month,
                                              input logic [4:0] day);
        logic [6:0] j;
        logic [4:0] m2;
        logic [7:0] sum;
        logic [4:0] fold1;
        logic [3:0] fold2;
        logic [2:0] rem;
        if (month == 4'd1 || month == 4'd2) begin
            j  = year + 7'd3;
            m2 = {month, 1'b0} + 5'd24;
        end
        else begin
            j  = year + 7'd4;
            m2 = {month, 1'b0};
        end
        sum = 8'(day) + 8'(m2) + 8'(month_term(month)) + 8'(j) + 8'(j[6:2]) + 8'd3;
        // Octal digits fold modulo 7 since 8 is 1 modulo 7.
        fold1 = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[7:6]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
        rem   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
        return (rem == 3'd0) ? 3'd7 : rem;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/calendar_time_step_adjuster_core.sv
// Calendar clock with step, clamp and load commands and weekday tracking.
//
//  Channel | Dir | Handshake          | Beat contents
//  s       | in  | s_tvalid/s_tready  | one command with its load values
//  m       | out | m_tvalid/m_tready  | all calendar fields after the command
//
//  A command beat is registered; when the command register moves on, it is
//  applied to the calendar and its result is written into the output register
//  at the same time, so a result beat passes the command register and then the
//  output register, with one beat per cycle sustained while m_tready is high.
//  The whole update (carry chain, month length, weekday) is one combinational
//  step between the command register and the calendar registers. Reset loads
//  2026-07-26 20:37:55, Sunday. A stalled output holds the command register;
//  s_tready stays high while the command register is empty or moving on.
`default_nettype none

module calendar_time_step_adjuster_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // cmd[3:0], new_year[10:4], new_month[14:11], new_day[19:15],
    // new_hour[24:20], new_minute[30:25], new_second[36:31], zero[39:37]
    input  wire logic [ctsa_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // year_out[6:0], month_out[10:7], day_out[15:11], hour_out[20:16],
    // minute_out[26:21], second_out[32:27], weekday_out[35:33], zero[39:36]
    output logic [ctsa_pkg::OUT_DATA_W-1:0]      m_tdata
);

    logic                               in_valid_reg;
    logic [ctsa_pkg::IN_DATA_W-1:0]     in_data_reg;
    logic                               m_tvalid_reg;
    logic [ctsa_pkg::OUT_DATA_W-1:0]    m_tdata_reg;
    logic                               adv;

    logic [6:0] year_reg,    year_next;
    logic [3:0] month_reg,   month_next;
    logic [4:0] day_reg,     day_next;
    logic [4:0] hour_reg,    hour_next;
    logic [5:0] minute_reg,  minute_next;
    logic [5:0] second_reg,  second_next;
    logic [2:0] weekday_reg, weekday_next;

    ctsa_pkg::ctsa_cmd_t cmd;
    logic [6:0] ld_year;
    logic [3:0] ld_month;
    logic [4:0] ld_day;
    logic [4:0] ld_hour;
    logic [5:0] ld_minute;
    logic [5:0] ld_second;

    logic sec_up, sec_dn, min_up, min_dn, hour_up, hour_dn, day_up, day_dn;
    logic do_clamp, do_load;
    logic [4:0] cur_len;

    logic [ctsa_pkg::OUT_DATA_W-1:0] next_packed;
    logic [ctsa_pkg::OUT_DATA_W-1:0] cur_packed;
    logic                            state_ok;

    // The command register moves on when the output register is free or being drained.
    assign adv      = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cmd       = ctsa_pkg::ctsa_cmd_t'(in_data_reg[3:0]);
    assign ld_year   = in_data_reg[10:4];
    assign ld_month  = in_data_reg[14:11];
    assign ld_day    = in_data_reg[19:15];
    assign ld_hour   = in_data_reg[24:20];
    assign ld_minute = in_data_reg[30:25];
    assign ld_second = in_data_reg[36:31];

    // Carry and borrow ripple from the commanded field upward.
    assign sec_up  = (cmd == ctsa_pkg::CMD_SEC_UP);
    assign sec_dn  = (cmd == ctsa_pkg::CMD_SEC_DOWN);
    assign min_up  = (cmd == ctsa_pkg::CMD_MIN_UP)
                     || (sec_up && second_reg == ctsa_pkg::SECOND_MAX);
    assign min_dn  = (cmd == ctsa_pkg::CMD_MIN_DOWN) || (sec_dn && second_reg == 6'd0);
    assign hour_up = (cmd == ctsa_pkg::CMD_HOUR_UP)
                     || (min_up && minute_reg == ctsa_pkg::MINUTE_MAX);
    assign hour_dn = (cmd == ctsa_pkg::CMD_HOUR_DOWN) || (min_dn && minute_reg == 6'd0);
    assign day_up  = (cmd == ctsa_pkg::CMD_DAY_UP)
                     || (hour_up && hour_reg == ctsa_pkg::HOUR_MAX);
    assign day_dn  = (cmd == ctsa_pkg::CMD_DAY_DOWN) || (hour_dn && hour_reg == 5'd0);
    assign do_clamp = (cmd == ctsa_pkg::CMD_CLAMP_DAY);
    assign do_load  = (cmd == ctsa_pkg::CMD_LOAD);
    assign cur_len  = ctsa_pkg::month_len(year_reg, month_reg);

    always_comb
    begin
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        weekday_next = weekday_reg;

        if (sec_up)
        begin
            second_next = (second_reg == ctsa_pkg::SECOND_MAX) ? 6'd0 : second_reg + 6'd1;
        end
        if (sec_dn)
        begin
            second_next = (second_reg == 6'd0) ? ctsa_pkg::SECOND_MAX : second_reg - 6'd1;
        end
        if (min_up)
        begin
            minute_next = (minute_reg == ctsa_pkg::MINUTE_MAX) ? 6'd0 : minute_reg + 6'd1;
        end
        if (min_dn)
        begin
            minute_next = (minute_reg == 6'd0) ? ctsa_pkg::MINUTE_MAX : minute_reg - 6'd1;
        end
        if (hour_up)
        begin
            hour_next = (hour_reg == ctsa_pkg::HOUR_MAX) ? 5'd0 : hour_reg + 5'd1;
        end
        if (hour_dn)
        begin
            hour_next = (hour_reg == 5'd0) ? ctsa_pkg::HOUR_MAX : hour_reg - 5'd1;
        end

        if (day_up)
        begin
            // A day left beyond the month end by a load also rolls to the next month.
            if (day_reg < cur_len)
            begin
                day_next = day_reg + 5'd1;
            end
            else
            begin
                day_next = 5'd1;
                if (month_reg < ctsa_pkg::MONTH_MAX)
                begin
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    month_next = 4'd1;
                    year_next  = (year_reg < ctsa_pkg::YEAR_MAX) ? year_reg + 7'd1 : 7'd0;
                end
            end
        end

        if (day_dn)
        begin
            if (day_reg > 5'd1)
            begin
                day_next = day_reg - 5'd1;
            end
            else
            begin
                if (month_reg > 4'd1)
                begin
                    month_next = month_reg - 4'd1;
                end
                else
                begin
                    month_next = ctsa_pkg::MONTH_MAX;
                    year_next  = (year_reg > 7'd0) ? year_reg - 7'd1 : ctsa_pkg::YEAR_MAX;
                end
                day_next = ctsa_pkg::month_len(year_next, month_next);
            end
        end

        if (do_clamp && day_reg > cur_len)
        begin
            day_next = cur_len;
        end

        if (do_load)
        begin
            year_next   = (ld_year > ctsa_pkg::YEAR_MAX) ? ctsa_pkg::YEAR_MAX : ld_year;
            month_next  = (ld_month == 4'd0) ? 4'd1
                        : ((ld_month > ctsa_pkg::MONTH_MAX) ? ctsa_pkg::MONTH_MAX : ld_month);
            day_next    = (ld_day == 5'd0) ? 5'd1 : ld_day;
            hour_next   = (ld_hour > ctsa_pkg::HOUR_MAX) ? ctsa_pkg::HOUR_MAX : ld_hour;
            minute_next = (ld_minute > ctsa_pkg::MINUTE_MAX) ? ctsa_pkg::MINUTE_MAX : ld_minute;
            second_next = (ld_second > ctsa_pkg::SECOND_MAX) ? ctsa_pkg::SECOND_MAX : ld_second;
        end

        if (day_up || day_dn || do_load)
        begin
            weekday_next = ctsa_pkg::weekday_of(year_next, month_next, day_next);
        end
    end

    assign next_packed = {4'd0, weekday_next, second_next, minute_next, hour_next,
                          day_next, month_next, year_next};
    assign cur_packed  = {4'd0, weekday_reg, second_reg, minute_reg, hour_reg,
                          day_reg, month_reg, year_reg};

    assign state_ok = month_reg >= 4'd1 && month_reg <= ctsa_pkg::MONTH_MAX
                      && day_reg != 5'd0 && hour_reg <= ctsa_pkg::HOUR_MAX
                      && minute_reg <= ctsa_pkg::MINUTE_MAX
                      && second_reg <= ctsa_pkg::SECOND_MAX
                      && year_reg <= ctsa_pkg::YEAR_MAX && weekday_reg != 3'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            year_reg     <= ctsa_pkg::RST_YEAR;
            month_reg    <= ctsa_pkg::RST_MONTH;
            day_reg      <= ctsa_pkg::RST_DAY;
            hour_reg     <= ctsa_pkg::RST_HOUR;
            minute_reg   <= ctsa_pkg::RST_MINUTE;
            second_reg   <= ctsa_pkg::RST_SECOND;
            weekday_reg  <= ctsa_pkg::RST_WEEKDAY;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (adv)
            begin
                year_reg    <= year_next;
                month_reg   <= month_next;
                day_reg     <= day_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                weekday_reg <= weekday_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (adv)
        begin
            m_tdata_reg <= next_packed;
        end
    end

`include "calendar_time_step_adjuster_core_assert.svh"

    `CTSA_ASSERT_ALWAYS(a_state_in_range, state_ok, "calendar state left its range")
    `CTSA_ASSERT_NEXT(a_result_matches_state, adv, m_tdata_reg == cur_packed,
                      "result beat differs from the calendar state")
    `CTSA_ASSERT_NEXT(a_result_valid_after_step, adv, m_tvalid_reg,
                      "stepped command produced no result beat")
    `CTSA_ASSERT_NEXT(a_cmd_held_on_stall, in_valid_reg && !adv,
                      in_valid_reg && $stable(in_data_reg), "stalled command was lost")

endmodule

`default_nettype wire
